### sv/oval_span_generator_assert.svh
// Assertion macros shared by the oval span generator checker.
`ifndef OVAL_SPAN_GENERATOR_ASSERT_SVH
`define OVAL_SPAN_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define OSG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("oval span generator check failed");

// Next-cycle implication, disabled while reset is high.
`define OSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("oval span generator check failed");

`endif

### sv/osg_pkg.sv
// Types and constants of the oval span generator.
`default_nettype none

package osg_pkg;

   localparam int DIAM_W     = 7;
   localparam int BOX_W      = 15;
   localparam int ROW_W      = 6;
   localparam int LEFT_W     = 7;
   localparam int RIGHT_W    = 17;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;
   localparam int RECIP_W    = 17;
   localparam int TERM_W     = 32;
   localparam int PROD_W     = 24;
   localparam int COL_W      = 8;
   localparam int LINE_W     = 7;
   localparam int CNT_W      = 5;

   localparam logic [DIAM_W-1:0] MAX_DIAMETER   = 7'd127;
   localparam logic [TERM_W:0]   UNIT_ONE       = 33'h0_0001_0000;
   localparam logic [CNT_W-1:0]  DIV_STEPS_LAST = 5'd16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_H,
      ST_DIV_V,
      ST_MUL,
      ST_SQR,
      ST_DEC_A0,
      ST_TEST_A0,
      ST_CHECK_ROW,
      ST_TEST_B,
      ST_DEC_A,
      ST_TEST_A,
      ST_EMIT_NEXT,
      ST_FINAL,
      ST_FLUSH
   } state_type;

   typedef enum logic {
      SPAN_START  = 1'b0,
      SPAN_EXPAND = 1'b1
   } span_kind_type;

   typedef struct packed {
      span_kind_type              kind;
      logic [ROW_W-1:0]           row;
      logic signed [LEFT_W-1:0]   left_edge;
      logic signed [RIGHT_W-1:0]  right_edge;
   } span_type;

endpackage

`default_nettype wire

### sv/oval_span_generator.sv
// Oval span generator: walks the upper-left quarter of an oval and emits its span breakpoints.
// Each oval runs two 17-step reciprocal divisions, then a setup, two passes of one shared
// 24x24 multiplier and a compare per column step and per row step, plus an output step per span;
// span output waits while the output register is held by a stalled consumer.
// One oval at a time: the next request is taken once its last span is in the output register.
// Synchronous active-high reset returns the sequencer to idle and empties the output stage.
`default_nettype none

module oval_span_generator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: horiz_diameter[6:0], vert_diameter[13:7], box_width[28:14], zeros.
   input  wire logic [osg_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // Fields from bit 0: row[5:0], left_edge[12:6], right_edge[29:13], zeros.
   output logic [osg_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Fields from bit 0: span_kind.
   output logic                               rsp_tuser,
   output logic                               rsp_tlast
);

   import osg_pkg::*;

   function automatic logic [DIAM_W-1:0] clamp_diam(input logic [DIAM_W-1:0] d);
      logic [DIAM_W-1:0] r;
      r = d;
      if (r == '0) begin
         r = {{(DIAM_W-1){1'b0}}, 1'b1};
      end
      if (r > MAX_DIAMETER) begin
         r = MAX_DIAMETER;
      end
      return r;
   endfunction

   state_type                 state_ff, state_in;
   state_type                 ret_ff, ret_in;
   logic                      horiz_sel_ff, horiz_sel_in;
   logic [DIAM_W-1:0]         h_ff, h_in;
   logic [DIAM_W-1:0]         v_ff, v_in;
   logic [BOX_W-1:0]          w_ff, w_in;
   logic [ROW_W-1:0]          mid_ff, mid_in;
   logic signed [COL_W-1:0]   x_ff, x_in;
   logic [LINE_W-1:0]         y_ff, y_in;
   logic [RECIP_W-1:0]        hr_ff, hr_in;
   logic [RECIP_W-1:0]        vr_ff, vr_in;
   logic [DIAM_W-1:0]         rem_ff, rem_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [TERM_W-1:0]         a_ff, a_in;
   logic [TERM_W-1:0]         b_ff, b_in;
   span_type                  pend_ff, pend_in;
   span_type                  out_ff, out_in;
   logic                      out_last_ff, out_last_in;
   logic                      out_valid_ff, out_valid_in;

   logic [DIAM_W-1:0]         h_clamp;
   logic [DIAM_W-1:0]         v_clamp;
   logic [DIAM_W-1:0]         v_less;
   logic [DIAM_W-1:0]         div_divisor;
   logic [DIAM_W:0]           rem_shift;
   logic                      div_ge;
   logic [DIAM_W:0]           rem_next;
   logic [9:0]                t_h;
   logic [9:0]                t_v;
   logic [COL_W-1:0]          t_sel;
   logic [RECIP_W-1:0]        r_sel;
   logic [PROD_W-1:0]         mul_x;
   logic [PROD_W-1:0]         mul_y;
   logic [2*PROD_W-1:0]       mul_p;
   logic [TERM_W-1:0]         sq;
   logic [TERM_W:0]           term_sum;
   logic                      sum_lt;
   logic                      sum_gt;
   logic                      x_pos;
   logic [LINE_W-1:0]         y_inc;
   logic                      y_le_mid;
   logic                      y_inc_le_mid;
   logic                      y_inc_lt_mid;
   logic                      y_ge_mid;
   logic                      out_free;
   span_type                  span_at_x;
   span_type                  span_full;

   assign h_clamp = clamp_diam(req_tdata[DIAM_W-1:0]);
   assign v_clamp = clamp_diam(req_tdata[2*DIAM_W-1:DIAM_W]);
   assign v_less  = v_clamp - {{(DIAM_W-1){1'b0}}, 1'b1};

   assign div_divisor = (state_ff == ST_DIV_H) ? h_ff : v_ff;
   assign rem_shift   = {rem_ff, (cnt_ff == DIV_STEPS_LAST)};
   assign div_ge      = rem_shift >= {1'b0, div_divisor};
   assign rem_next    = div_ge ? (rem_shift - {1'b0, div_divisor}) : rem_shift;

   assign t_h   = {3'b000, h_ff} - {x_ff[COL_W-1], x_ff, 1'b0} + 10'd1;
   assign t_v   = {3'b000, v_ff} - {2'b00, y_ff, 1'b0} - 10'd1;
   assign t_sel = horiz_sel_ff ? t_h[COL_W-1:0] : t_v[COL_W-1:0];
   assign r_sel = horiz_sel_ff ? hr_ff : vr_ff;

   assign mul_x = (state_ff == ST_SQR) ? prod_ff : {{(PROD_W-COL_W){1'b0}}, t_sel};
   assign mul_y = (state_ff == ST_SQR) ? prod_ff : {{(PROD_W-RECIP_W){1'b0}}, r_sel};
   assign mul_p = {{PROD_W{1'b0}}, mul_x} * {{PROD_W{1'b0}}, mul_y};
   assign sq    = mul_p[TERM_W+15:16];

   assign term_sum = {1'b0, a_ff} + {1'b0, b_ff};
   assign sum_lt   = term_sum < UNIT_ONE;
   assign sum_gt   = term_sum > UNIT_ONE;

   assign x_pos        = !x_ff[COL_W-1] && (x_ff != '0);
   assign y_inc        = y_ff + {{(LINE_W-1){1'b0}}, 1'b1};
   assign y_le_mid     = y_ff <= {1'b0, mid_ff};
   assign y_inc_le_mid = y_inc <= {1'b0, mid_ff};
   assign y_inc_lt_mid = y_inc < {1'b0, mid_ff};
   assign y_ge_mid     = y_ff >= {1'b0, mid_ff};

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      span_at_x.kind       = SPAN_START;
      span_at_x.row        = y_ff[ROW_W-1:0];
      span_at_x.left_edge  = x_ff[LEFT_W-1:0];
      span_at_x.right_edge = {2'b00, w_ff} - {{(RIGHT_W-COL_W){x_ff[COL_W-1]}}, x_ff};
      span_full.kind       = SPAN_EXPAND;
      span_full.row        = y_ff[ROW_W-1:0];
      span_full.left_edge  = '0;
      span_full.right_edge = {2'b00, w_ff};
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      horiz_sel_in = horiz_sel_ff;
      h_in         = h_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      mid_in       = mid_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      hr_in        = hr_ff;
      vr_in        = vr_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      pend_in      = pend_ff;
      out_in       = out_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff;
      req_tready   = 1'b0;

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               h_in     = h_clamp;
               v_in     = v_clamp;
               w_in     = req_tdata[2*DIAM_W+BOX_W-1:2*DIAM_W];
               mid_in   = v_less[DIAM_W-1:1];
               x_in     = {2'b00, h_clamp[DIAM_W-1:1]};
               y_in     = '0;
               rem_in   = '0;
               cnt_in   = DIV_STEPS_LAST;
               state_in = ST_DIV_H;
            end
         end
         ST_DIV_H: begin
            rem_in = rem_next[DIAM_W-1:0];
            hr_in  = {hr_ff[RECIP_W-2:0], div_ge};
            cnt_in = cnt_ff - {{(CNT_W-1){1'b0}}, 1'b1};
            if (cnt_ff == '0) begin
               rem_in   = '0;
               cnt_in   = DIV_STEPS_LAST;
               state_in = ST_DIV_V;
            end
         end
         ST_DIV_V: begin
            rem_in = rem_next[DIAM_W-1:0];
            vr_in  = {vr_ff[RECIP_W-2:0], div_ge};
            cnt_in = cnt_ff - {{(CNT_W-1){1'b0}}, 1'b1};
            if (cnt_ff == '0) begin
               horiz_sel_in = 1'b0;
               ret_in       = ST_DEC_A0;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = mul_p[PROD_W-1:0];
            state_in = ST_SQR;
         end
         ST_SQR: begin
            if (horiz_sel_ff) begin
               a_in = sq;
            end else begin
               b_in = sq;
            end
            state_in = ret_ff;
         end
         ST_DEC_A0: begin
            x_in         = x_ff - {{(COL_W-1){1'b0}}, 1'b1};
            horiz_sel_in = 1'b1;
            ret_in       = ST_TEST_A0;
            state_in     = ST_MUL;
         end
         ST_TEST_A0: begin
            if (sum_lt) begin
               state_in = ST_DEC_A0;
            end else begin
               pend_in  = span_at_x;
               state_in = ST_CHECK_ROW;
            end
         end
         ST_CHECK_ROW: begin
            if (x_pos) begin
               y_in = y_inc;
               if (y_inc_le_mid) begin
                  horiz_sel_in = 1'b0;
                  ret_in       = ST_TEST_B;
                  state_in     = ST_MUL;
               end else begin
                  state_in = ST_FINAL;
               end
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_TEST_B: begin
            if (sum_gt) begin
               y_in = y_inc;
               if (y_inc_lt_mid) begin
                  horiz_sel_in = 1'b0;
                  ret_in       = ST_TEST_B;
                  state_in     = ST_MUL;
               end else begin
                  state_in = ST_FINAL;
               end
            end else if (y_ge_mid) begin
               state_in = ST_FINAL;
            end else begin
               state_in = ST_DEC_A;
            end
         end
         ST_DEC_A: begin
            x_in         = x_ff - {{(COL_W-1){1'b0}}, 1'b1};
            horiz_sel_in = 1'b1;
            ret_in       = ST_TEST_A;
            state_in     = ST_MUL;
         end
         ST_TEST_A: begin
            if (x_pos && sum_lt) begin
               state_in = ST_DEC_A;
            end else begin
               state_in = ST_EMIT_NEXT;
            end
         end
         ST_EMIT_NEXT: begin
            if (out_free) begin
               out_in         = pend_ff;
               out_last_in    = 1'b0;
               out_valid_in   = 1'b1;
               pend_in        = span_at_x;
               pend_in.kind   = SPAN_EXPAND;
               state_in       = ST_CHECK_ROW;
            end
         end
         ST_FINAL: begin
            if (x_pos && y_le_mid) begin
               if (out_free) begin
                  out_in       = pend_ff;
                  out_last_in  = 1'b0;
                  out_valid_in = 1'b1;
                  pend_in      = span_full;
                  state_in     = ST_FLUSH;
               end
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_in       = pend_ff;
               out_last_in  = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         horiz_sel_ff <= 1'b0;
         x_ff         <= '0;
         y_ff         <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         horiz_sel_ff <= horiz_sel_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff        <= h_in;
      v_ff        <= v_in;
      w_ff        <= w_in;
      mid_ff      <= mid_in;
      hr_ff       <= hr_in;
      vr_ff       <= vr_in;
      rem_ff      <= rem_in;
      prod_ff     <= prod_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-ROW_W-LEFT_W-RIGHT_W){1'b0}},
                        out_ff.right_edge, out_ff.left_edge, out_ff.row};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

### sv/osg_checker.sv
// Port-level checker for the oval span generator and its bind to the top level.
`default_nettype none

`include "oval_span_generator_assert.svh"

module osg_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic [osg_pkg::REQ_DATA_W-1:0] req_tdata,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [osg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                           rsp_tuser,
   input wire logic                           rsp_tlast
);

   import osg_pkg::*;

   logic [ROW_W-1:0] rsp_row;
   logic             req_seen;

   assign rsp_row  = rsp_tdata[ROW_W-1:0];
   assign req_seen = req_tvalid && req_tready && (req_tdata[0] || !req_tdata[0]);

   // A stalled result transfer keeps its payload.
   `OSG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))

   // Once an oval is taken the block is busy for at least the next cycle.
   `OSG_ASSERT_NEXT(a_busy_after_req, clock, reset, req_seen, !req_tready)

   // Start spans sit on row zero and expansion spans always lie below it.
   `OSG_ASSERT_IMP(a_kind_row, clock, reset, rsp_tvalid, (rsp_tuser == 1'b0) == (rsp_row == '0))

endmodule

bind oval_span_generator osg_checker u_osg_checker (.*);

`default_nettype wire
